// ===== rtl/tide_pkg.sv =====
`timescale 1ns / 1ps
// tide_pkg: shared constants, codes and types of the toy ISA decode/execute block.
// No dependencies; imported by every other file in rtl/ except tide_ram.
package tide_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned RegDepth     = 8;
  localparam int unsigned RegAddrW     = $clog2(RegDepth);
  localparam int unsigned WordW        = 16;
  localparam int unsigned OutValW      = 16;

  // request function codes
  localparam logic [1:0] FUNC_EXEC    = 2'd0;
  localparam logic [1:0] FUNC_PRELOAD = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // opcodes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_AND   = 4'd2;
  localparam logic [3:0] OP_OR    = 4'd3;
  localparam logic [3:0] OP_XOR   = 4'd4;
  localparam logic [3:0] OP_LOAD  = 4'd5;
  localparam logic [3:0] OP_STORE = 4'd6;

  // instruction type and operand mode
  localparam logic TYPE_ALU = 1'b0;
  localparam logic MODE_REG = 1'b0;
  localparam logic MODE_IMM = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  typedef struct packed {
    logic                wrote;
    logic [RegAddrW-1:0] idx;
    logic [1:0]          status;
  } res_ctl_t;

endpackage

// ===== rtl/tide_ram.sv =====
`timescale 1ns / 1ps
// tide_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tide_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tide_regfile.sv =====
`timescale 1ns / 1ps
// tide_regfile: eight-entry register file, two RAM copies for two read ports,
// per-entry valid bits for the zero reset and a same-cycle write bypass. Uses tide_pkg, tide_ram.
module tide_regfile #(
  parameter int unsigned DataWidth = tide_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [tide_pkg::RegAddrW-1:0] waddr_i,
  input  logic [DataWidth-1:0]          wdata_i,
  input  logic                          re_i,
  input  logic [tide_pkg::RegAddrW-1:0] raddr_a_i,
  input  logic [tide_pkg::RegAddrW-1:0] raddr_b_i,
  output logic [DataWidth-1:0]          rdata_a_o,
  output logic [DataWidth-1:0]          rdata_b_o
);
  import tide_pkg::*;

  logic [RegDepth-1:0]  valid_q, valid_d;
  logic                 va_q, vb_q;
  logic                 byp_a_q, byp_b_q;
  logic [DataWidth-1:0] byp_data_q;
  logic [DataWidth-1:0] ram_a, ram_b;

  tide_ram #(.Width(DataWidth), .Depth(RegDepth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_a_i),
    .rdata_o (ram_a)
  );

  tide_ram #(.Width(DataWidth), .Depth(RegDepth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_b_i),
    .rdata_o (ram_b)
  );

  always_comb begin
    valid_d = valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (re_i) begin
        va_q    <= valid_q[raddr_a_i];
        vb_q    <= valid_q[raddr_b_i];
        byp_a_q <= we_i && (waddr_i == raddr_a_i);
        byp_b_q <= we_i && (waddr_i == raddr_b_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      byp_data_q <= wdata_i;
    end
  end

  assign rdata_a_o = byp_a_q ? byp_data_q : (va_q ? ram_a : '0);
  assign rdata_b_o = byp_b_q ? byp_data_q : (vb_q ? ram_b : '0);

endmodule

// ===== rtl/tide_alu.sv =====
`timescale 1ns / 1ps
// tide_alu: decode of one request and the arithmetic-logical result.
// Uses tide_pkg.
module tide_alu #(
  parameter int unsigned DataWidth = tide_pkg::DataWidthDef
) (
  input  logic [1:0]                    func_i,
  input  logic [tide_pkg::WordW-1:0]    instr_word_i,
  input  logic [tide_pkg::RegAddrW-1:0] target_reg_i,
  input  logic [tide_pkg::WordW-1:0]    preload_value_i,
  input  logic [DataWidth-1:0]          rdata_a_i,
  input  logic [DataWidth-1:0]          rdata_b_i,
  output tide_pkg::res_ctl_t            ctl_o,
  output logic [DataWidth-1:0]          value_o
);
  import tide_pkg::*;

  logic                 itype;
  logic [3:0]           opc;
  logic                 mode;
  logic [RegAddrW-1:0]  rd;
  logic [3:0]           src;
  logic [DataWidth-1:0] first;
  logic [DataWidth-1:0] second;
  logic [DataWidth-1:0] res;
  logic                 op_ok;

  assign itype  = instr_word_i[15];
  assign opc    = instr_word_i[14:11];
  assign mode   = instr_word_i[10];
  assign rd     = instr_word_i[9:7];
  assign src    = instr_word_i[6:3];
  assign first  = (mode == MODE_IMM) ? DataWidth'(src) : rdata_a_i;
  assign second = rdata_b_i;

  always_comb begin
    res   = first;
    op_ok = 1'b1;
    if (itype == TYPE_ALU) begin
      case (opc)
        OP_ADD:  res = first + second;
        OP_SUB:  res = first - second;
        OP_AND:  res = first & second;
        OP_OR:   res = first | second;
        OP_XOR:  res = first ^ second;
        default: op_ok = 1'b0;
      endcase
    end else begin
      op_ok = (opc inside {OP_LOAD, OP_STORE});
    end
  end

  always_comb begin
    ctl_o   = '{wrote: 1'b0, idx: '0, status: ST_IGNORED};
    value_o = '0;
    case (func_i)
      FUNC_PRELOAD: begin
        ctl_o   = '{wrote: 1'b1, idx: target_reg_i, status: ST_DONE};
        value_o = DataWidth'(preload_value_i);
      end
      FUNC_READ: begin
        ctl_o   = '{wrote: 1'b0, idx: target_reg_i, status: ST_READ};
        value_o = rdata_a_i;
      end
      FUNC_EXEC: begin
        if (op_ok) begin
          ctl_o   = '{wrote: 1'b1, idx: rd, status: ST_DONE};
          value_o = res;
        end
      end
      default: begin
        ctl_o   = '{wrote: 1'b0, idx: '0, status: ST_IGNORED};
        value_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/toy_isa_decode_execute.sv =====
`timescale 1ns / 1ps
// toy_isa_decode_execute: top level, request handshake, execute stage and output register.
// Uses tide_pkg, tide_regfile, tide_alu.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i / in_stall_o   func, instr_word, target_reg, preload_value
//   result    out        out_valid_o / out_stall_i wrote_reg, dest_index, dest_value, status
//
// One request per cycle while in_stall_o is low. The accepting edge reads both register-file
// RAM ports; the execute stage then executes, writes back and loads the output register.
// A write in the same edge as a later read is forwarded by the register file.
// Reset clears all registers to zero at once through per-entry valid bits.
// A stalled result holds the execute stage, which then stalls the request side.
module toy_isa_decode_execute #(
  parameter int unsigned DATA_WIDTH = tide_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [tide_pkg::WordW-1:0]    instr_word_i,
  input  logic [tide_pkg::RegAddrW-1:0] target_reg_i,
  input  logic [tide_pkg::WordW-1:0]    preload_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          wrote_reg_o,
  output logic [tide_pkg::RegAddrW-1:0] dest_index_o,
  output logic [tide_pkg::OutValW-1:0]  dest_value_o,
  output logic [1:0]                    status_o
);
  import tide_pkg::*;

  logic                  in_accept;
  logic                  s1_adv;
  logic                  out_free;
  logic                  s1_valid_q;
  logic [1:0]            s1_func_q;
  logic [WordW-1:0]      s1_word_q;
  logic [RegAddrW-1:0]   s1_tgt_q;
  logic [WordW-1:0]      s1_pre_q;
  logic [RegAddrW-1:0]   raddr_a;
  logic [RegAddrW-1:0]   raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;
  res_ctl_t              ctl;
  logic [DATA_WIDTH-1:0] value;
  logic                  out_valid_q;
  res_ctl_t              out_ctl_q;
  logic [OutValW-1:0]    out_val_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign raddr_a = (func_i == FUNC_READ) ? target_reg_i : instr_word_i[5:3];
  assign raddr_b = instr_word_i[2:0];

  tide_regfile #(.DataWidth(DATA_WIDTH)) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (s1_adv && ctl.wrote),
    .waddr_i   (ctl.idx),
    .wdata_i   (value),
    .re_i      (in_accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  tide_alu #(.DataWidth(DATA_WIDTH)) u_alu (
    .func_i          (s1_func_q),
    .instr_word_i    (s1_word_q),
    .target_reg_i    (s1_tgt_q),
    .preload_value_i (s1_pre_q),
    .rdata_a_i       (rdata_a),
    .rdata_b_i       (rdata_b),
    .ctl_o           (ctl),
    .value_o         (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_word_q <= instr_word_i;
      s1_tgt_q  <= target_reg_i;
      s1_pre_q  <= preload_value_i;
    end
    if (s1_adv) begin
      out_ctl_q <= ctl;
      out_val_q <= OutValW'(value);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wrote_reg_o  = out_ctl_q.wrote;
  assign dest_index_o = out_ctl_q.idx;
  assign dest_value_o = out_val_q;
  assign status_o     = out_ctl_q.status;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for toy_isa_decode_execute, with a register-file shadow
// that predicts every writeback, random idling on both channels and long back-pressure.
// Depends on rtl/tide_pkg.sv and rtl/toy_isa_decode_execute.sv.
module testbench;
  import tide_pkg::*;

  localparam int unsigned DataW = DataWidthDef;
  localparam int unsigned IdleLimit = 1000;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  localparam logic TYPE_XFER = 1'b1;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic                wrote;
    logic [RegAddrW-1:0] idx;
    logic [OutValW-1:0]  value;
    logic [1:0]          status;
  } writeback_t;

  class exec_scoreboard;
    logic [DataW-1:0] shadow_regs [RegDepth];
    writeback_t expected_writebacks [$];
    int errors, checked, n_exec, n_preload, n_read, n_ignored;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      errors = 0;
      checked = 0;
      n_exec = 0;
      n_preload = 0;
      n_read = 0;
      n_ignored = 0;
    endfunction

    function int pending();
      return expected_writebacks.size();
    endfunction

    function void note_request(logic [1:0] func, logic [WordW-1:0] word,
                               logic [RegAddrW-1:0] tgt, logic [WordW-1:0] preload);
      writeback_t wb;
      logic [DataW-1:0] first, second, res;
      logic legal;
      wb = '{1'b0, '0, '0, ST_IGNORED};
      case (func)
        FUNC_PRELOAD: begin
          shadow_regs[tgt] = DataW'(preload);
          wb = '{1'b1, tgt, OutValW'(shadow_regs[tgt]), ST_DONE};
          n_preload++;
        end
        FUNC_READ: begin
          wb = '{1'b0, tgt, OutValW'(shadow_regs[tgt]), ST_READ};
          n_read++;
        end
        FUNC_EXEC: begin
          first = (word[10] == MODE_IMM) ? DataW'(word[6:3]) : shadow_regs[word[5:3]];
          second = shadow_regs[word[2:0]];
          legal = 1'b1;
          res = '0;
          if (word[15] == TYPE_ALU) begin
            case (word[14:11])
              OP_ADD: res = first + second;
              OP_SUB: res = first - second;
              OP_AND: res = first & second;
              OP_OR: res = first | second;
              OP_XOR: res = first ^ second;
              default: legal = 1'b0;
            endcase
          end else if (word[14:11] == OP_LOAD || word[14:11] == OP_STORE) begin
            res = first;
          end else begin
            legal = 1'b0;
          end
          if (legal) begin
            shadow_regs[word[9:7]] = res;
            wb = '{1'b1, word[9:7], OutValW'(res), ST_DONE};
            n_exec++;
          end else begin
            n_ignored++;
          end
        end
        default: n_ignored++;
      endcase
      expected_writebacks.push_back(wb);
    endfunction

    function void check_result(writeback_t got);
      writeback_t exp;
      if (expected_writebacks.size() == 0) begin
        $error("result with nothing expected: wrote_reg %0d dest_index %0d dest_value %h status %0d",
               got.wrote, got.idx, got.value, got.status);
        errors++;
        return;
      end
      exp = expected_writebacks.pop_front();
      checked++;
      if (got.wrote !== exp.wrote) begin
        $error("wrote_reg: expected %0d, actual %0d", exp.wrote, got.wrote);
        errors++;
      end
      if (got.idx !== exp.idx) begin
        $error("dest_index: expected %0d, actual %0d", exp.idx, got.idx);
        errors++;
      end
      if (got.value !== exp.value) begin
        $error("dest_value: expected %h, actual %h", exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          func_i = FUNC_EXEC;
  logic [WordW-1:0]    instr_word_i = '0;
  logic [RegAddrW-1:0] target_reg_i = '0;
  logic [WordW-1:0]    preload_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                wrote_reg_o;
  logic [RegAddrW-1:0] dest_index_o;
  logic [OutValW-1:0]  dest_value_o;
  logic [1:0]          status_o;

  exec_scoreboard sb = new();
  bit receiver_quiet = 1'b0;
  int hold_request_cycles = 0;

  toy_isa_decode_execute #(
    .DATA_WIDTH(DataW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .instr_word_i   (instr_word_i),
    .target_reg_i   (target_reg_i),
    .preload_value_i(preload_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wrote_reg_o    (wrote_reg_o),
    .dest_index_o   (dest_index_o),
    .dest_value_o   (dest_value_o),
    .status_o       (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] encode(logic typ, logic [3:0] opc, logic mode,
                                              logic [2:0] rd, logic [3:0] src, logic [2:0] rs2);
    return {typ, opc, mode, rd, src, rs2};
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high if no gap
  task automatic send_request(logic [1:0] func, logic [WordW-1:0] word,
                              logic [RegAddrW-1:0] tgt, logic [WordW-1:0] preload,
                              int max_gap);
    int gap;
    in_valid_i <= 1'b1;
    func_i <= func;
    instr_word_i <= word;
    target_reg_i <= tgt;
    preload_value_i <= preload;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(func, word, tgt, preload);
    @(negedge clk_i);
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int max_gap);
    int pick;
    logic [1:0] func;
    logic [WordW-1:0] word, preload;
    logic [3:0] opc;
    logic typ;
    pick = $urandom_range(0, 99);
    func = FUNC_EXEC;
    word = WordW'($urandom);
    preload = WordW'($urandom);
    typ = word[15];
    if (pick < 55) begin
      opc = (typ == TYPE_ALU) ? 4'($urandom_range(OP_ADD, OP_XOR))
                              : 4'($urandom_range(OP_LOAD, OP_STORE));
      word[14:11] = opc;
    end else if (pick < 70) begin
      func = FUNC_PRELOAD;
      case ($urandom_range(0, 3))
        0: preload = '0;
        1: preload = '1;
        2: preload = {1'b1, {(WordW - 1){1'b0}}};
        default: ;
      endcase
    end else if (pick < 85) begin
      func = FUNC_READ;
    end else if (pick >= 95) begin
      func = FUNC_UNDEF;
    end
    send_request(func, word, RegAddrW'($urandom), preload, max_gap);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    writeback_t got;
    int n;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request_cycles > 0) begin
        n = hold_request_cycles;
        hold_request_cycles = 0;
      end else begin
        n = receiver_quiet ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{wrote_reg_o, dest_index_o, dest_value_o, status_o};
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("timeout after %0d idle cycles", IdleLimit);
    $display("toy_isa_decode_execute: mismatch");
    $finish;
  end

  initial begin
    bit quiet;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(FUNC_READ, '0, 3'd0, '0, 3);
    send_request(FUNC_PRELOAD, '0, 3'd1, '1, 3);
    send_request(FUNC_PRELOAD, '0, 3'd2, 16'h0001, 3);
    send_request(FUNC_PRELOAD, '0, 3'd7, 16'h8000, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_ADD, MODE_REG, 3'd3, 4'd1, 3'd2), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_SUB, MODE_IMM, 3'd4, 4'd0, 3'd2), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_AND, MODE_REG, 3'd5, 4'd9, 3'd7), '0, '0, 2);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_OR, MODE_IMM, 3'd6, 4'd15, 3'd7), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_XOR, MODE_REG, 3'd0, 4'd7, 3'd1), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_XFER, OP_LOAD, MODE_IMM, 3'd1, 4'd15, 3'd0), '0, '0, 2);
    send_request(FUNC_EXEC, encode(TYPE_XFER, OP_STORE, MODE_REG, 3'd2, 4'd15, 3'd5), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_LOAD, MODE_REG, 3'd3, 4'd1, 3'd1), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_ALU, OP_UNUSED_HI, MODE_IMM, 3'd4, 4'd2, 3'd2), '0, '0, 1);
    send_request(FUNC_EXEC, encode(TYPE_XFER, OP_ADD, MODE_IMM, 3'd5, 4'd3, 3'd3), '0, '0, 0);
    send_request(FUNC_EXEC, encode(TYPE_XFER, OP_UNUSED_HI, MODE_REG, 3'd6, 4'd4, 3'd4), '0, '0, 0);
    send_request(FUNC_UNDEF, '1, 3'd7, '1, 2);
    for (int r = 0; r < RegDepth; r++) send_request(FUNC_READ, '0, RegAddrW'(r), '0, 1);

    for (int phase = 0; phase < 9; phase++) begin
      quiet = (phase % 3 == 1);
      receiver_quiet = quiet;
      if (phase == 2) begin
        hold_request_cycles = 80;
        repeat (30) send_random(0);
      end
      if (phase == 5) wait_drained();
      repeat (44) send_random(quiet ? 0 : 19);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d executes, %0d preloads, %0d reads, %0d ignored requests",
             sb.n_exec, sb.n_preload, sb.n_read, sb.n_ignored);
    $display("%0d results checked, %0d field errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("toy_isa_decode_execute: match");
    end else begin
      $display("toy_isa_decode_execute: mismatch");
    end
    $finish;
  end

endmodule
